// ----- hw/rtl/i2a_pkg.sv -----
// Shared types, character codes and command codes of the integer to ASCII formatter.
package i2a_pkg;

	localparam int VALUE_W = 32;
	localparam int DIGITS  = 10;
	localparam int BCD_W   = 4 * DIGITS;
	localparam int CHAR_W  = 7;

	localparam logic [1:0] CMD_UDEC = 2'd0;
	localparam logic [1:0] CMD_SDEC = 2'd1;
	localparam logic [1:0] CMD_HEX  = 2'd2;

	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
	localparam logic [CHAR_W-1:0] CHAR_A     = 7'h61;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2d;
	localparam logic [CHAR_W-1:0] CHAR_NINE  = 7'h39;
	localparam logic [CHAR_W-1:0] CHAR_F     = 7'h66;

	typedef struct packed {
		logic               start;
		logic [VALUE_W-1:0] bin;
	} i2a_bcd_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [BCD_W-1:0] bcd;
	} i2a_bcd_res_t;

	function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
		logic [CHAR_W-1:0] r;
		if (d < 4'd10) begin
			r = CHAR_ZERO + {3'b000, d};
		end else begin
			r = CHAR_A + {3'b000, d} - 7'd10;
		end
		return r;
	endfunction

endpackage

// ----- hw/rtl/integer_to_ascii_formatter.sv -----
// Top level of the integer to ASCII formatter: command sequencer and output register.
//
// Input channel s_*: one item carries a 32-bit value and a 2-bit command
// (unsigned decimal, signed decimal, lowercase hex). Output channel m_*:
// one item per ASCII character, most significant first, tlast on the final
// character of a value. A command code of 3 is taken and produces nothing,
// and the next item can be taken in the following cycle.
// One value is worked on at a time; s_tready is high only while idle.
// Decimal values go through a binary to BCD converter that shifts one bit per
// cycle; the sequencer takes its result when the converter's done flag is set,
// then leading zero digits are dropped at one per cycle (up to 9) and the
// emission starts. A decimal value gives up to 11 characters, the minus sign
// included. Hex needs no conversion: up to 7 dropped zeros and up to 8
// characters. Reset clears the sequencer and the output valid flag. When the
// receiver stalls, the character in the output register holds and the
// sequencer waits until it is taken.
module integer_to_ascii_formatter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // [31:0] value, [33:32] command, [39:34] zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [6:0] character, [7] zero
	output logic        m_tlast
);
	import i2a_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CONV = 2'd1;
	localparam logic [1:0] ST_SKIP = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	logic [1:0]         state_q;
	logic [BCD_W-1:0]   dig_q;
	logic [3:0]         rem_q;
	logic               minus_q;
	logic               out_valid_q;
	logic [CHAR_W-1:0]  out_char_q;
	logic               out_last_q;

	logic [VALUE_W-1:0] in_value;
	logic [1:0]         in_cmd;
	logic               accept;
	logic               out_free;
	logic               neg;
	logic [VALUE_W-1:0] mag;
	logic [3:0]         top_digit;
	i2a_bcd_req_t       bcd_req;
	i2a_bcd_res_t       bcd_res;

	assign in_value  = s_tdata[31:0];
	assign in_cmd    = s_tdata[33:32];
	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign out_free  = !out_valid_q || m_tready;
	assign neg       = (in_cmd == CMD_SDEC) && in_value[VALUE_W-1];
	assign mag       = neg ? (~in_value + 32'd1) : in_value;
	assign top_digit = dig_q[BCD_W-1 -: 4];

	assign bcd_req.start = accept && ((in_cmd == CMD_UDEC) || (in_cmd == CMD_SDEC));
	assign bcd_req.bin   = mag;

	i2a_dabble u_dabble (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (bcd_req),
		.res    (bcd_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rem_q       <= '0;
			minus_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						minus_q <= neg;
						if (in_cmd == CMD_HEX) begin
							rem_q   <= 4'd8;
							state_q <= ST_SKIP;
						end else if (bcd_req.start) begin
							state_q <= ST_CONV;
						end
					end
				end
				ST_CONV: begin
					if (bcd_res.done) begin
						rem_q   <= 4'(DIGITS);
						state_q <= ST_SKIP;
					end
				end
				ST_SKIP: begin
					if (top_digit == 4'd0 && rem_q > 4'd1) begin
						rem_q <= rem_q - 4'd1;
					end else begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						if (minus_q) begin
							minus_q <= 1'b0;
						end else begin
							rem_q <= rem_q - 4'd1;
							if (rem_q == 4'd1) begin
								state_q <= ST_IDLE;
							end
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept && in_cmd == CMD_HEX) begin
			dig_q <= {in_value, 8'h00};
		end else if (state_q == ST_CONV && bcd_res.done) begin
			dig_q <= bcd_res.bcd;
		end else if (state_q == ST_SKIP && top_digit == 4'd0 && rem_q > 4'd1) begin
			dig_q <= {dig_q[BCD_W-5:0], 4'h0};
		end else if (state_q == ST_EMIT && out_free && !minus_q) begin
			dig_q <= {dig_q[BCD_W-5:0], 4'h0};
		end
		if (state_q == ST_EMIT && out_free) begin
			if (minus_q) begin
				out_char_q <= CHAR_MINUS;
				out_last_q <= 1'b0;
			end else begin
				out_char_q <= digit_char(top_digit);
				out_last_q <= (rem_q == 4'd1);
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_char_q};
	assign m_tlast  = out_last_q;

	a_done_in_conv: assert property (@(posedge clk) disable iff (!arst_n)
		bcd_res.done |-> (state_q == ST_CONV))
		else $error("converter finished outside the conversion state");

	a_conv_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CONV) && !bcd_res.done |-> bcd_res.busy)
		else $error("conversion state without a running converter");

	a_rem_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SKIP || state_q == ST_EMIT) |-> (rem_q != 4'd0))
		else $error("no digits left while emitting");

	a_char_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ((out_char_q >= CHAR_ZERO && out_char_q <= CHAR_NINE)
			|| (out_char_q >= CHAR_A && out_char_q <= CHAR_F)
			|| (out_char_q == CHAR_MINUS)))
		else $error("illegal character on the output");

	a_minus_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_char_q == CHAR_MINUS) |-> !out_last_q)
		else $error("minus sign marked as last character");

endmodule

// ----- hw/rtl/i2a_dabble.sv -----
// Iterative binary to BCD converter, one shift-and-add-three step per cycle.
module i2a_dabble (
	input  logic                 clk,
	input  logic                 arst_n,
	input  i2a_pkg::i2a_bcd_req_t req,
	output i2a_pkg::i2a_bcd_res_t res
);
	import i2a_pkg::*;

	localparam int CNT_W = $clog2(VALUE_W);

	logic               busy_q;
	logic               done_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [BCD_W-1:0]   bcd_q;
	logic [VALUE_W-1:0] bin_q;
	logic [BCD_W-1:0]   adj;

	always_comb begin
		for (int i = 0; i < DIGITS; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) begin
				adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end else begin
				adj[4*i +: 4] = bcd_q[4*i +: 4];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_W'(VALUE_W - 1));
			if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(VALUE_W - 1)) begin
					busy_q <= 1'b0;
				end
			end else if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			{bcd_q, bin_q} <= {adj[BCD_W-2:0], bin_q, 1'b0};
		end else if (req.start) begin
			bcd_q <= '0;
			bin_q <= req.bin;
		end
	end

	assign res.busy = busy_q;
	assign res.done = done_q;
	assign res.bcd  = bcd_q;

endmodule
